[hw/rtl/sigmoid_taylor_exp_defines.svh]
// ----------------------------------------------------------------------------
// sigmoid_taylor_exp_defines
// assertion macros used by the sigmoid pipeline top
// ----------------------------------------------------------------------------
`ifndef SIGMOID_TAYLOR_EXP_DEFINES_SVH
`define SIGMOID_TAYLOR_EXP_DEFINES_SVH

// same-cycle implication
`define STE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sigmoid_taylor_exp: assertion failed");

// next-cycle implication
`define STE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sigmoid_taylor_exp: assertion failed");

`endif

[hw/rtl/ste_pkg.sv]
// ----------------------------------------------------------------------------
// ste_pkg
// widths and bus types of the sigmoid taylor pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package ste_pkg;
    localparam int TERMS    = 32;
    localparam int TW       = 56;
    localparam int NXW      = 17;
    localparam int RW       = 34;
    localparam int FRAC     = 40;
    localparam int QW       = 17;
    localparam int REMW     = 58;
    localparam int SHW      = REMW + 12;

    typedef struct packed {
        logic                  valid;
        logic signed [NXW-1:0] nx;
        logic signed [TW-1:0]  term;
        logic signed [TW-1:0]  sum;
    } t_term_bus;
endpackage
`default_nettype wire

[hw/rtl/ste_if.sv]
// ----------------------------------------------------------------------------
// ste_if
// valid/ready channels for the activation and the sigmoid word
// ----------------------------------------------------------------------------
`default_nettype none
interface ste_x_if;
    logic        valid;
    logic        ready;
    logic [15:0] x_in;
    modport source (output valid, output x_in, input ready);
    modport sink   (input valid, input x_in, output ready);
endinterface

interface ste_y_if;
    logic        valid;
    logic        ready;
    logic [15:0] y_out;
    modport source (output valid, output y_out, input ready);
    modport sink   (input valid, input y_out, output ready);
endinterface
`default_nettype wire

[hw/rtl/ste_term.sv]
// ----------------------------------------------------------------------------
// ste_term
// one taylor term: t_k = floor(floor(t*(-x)/2^12) * floor(2^32/k) / 2^32)
// ----------------------------------------------------------------------------
`default_nettype none
module ste_term (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic [ste_pkg::RW-1:0]    i_recip,
    input  wire ste_pkg::t_term_bus        i_bus,
    output ste_pkg::t_term_bus             o_bus
);
    import ste_pkg::*;

    logic signed [TW+NXW-1:0] w_prod;
    logic signed [TW-1:0]     n_p;
    logic signed [TW-33:0]    w_ph;
    logic signed [TW+RW-32:0] w_hi;
    logic [31+RW:0]           w_lo;

    logic                     r1_valid;
    logic signed [NXW-1:0]    r1_nx;
    logic signed [TW-1:0]     r1_sum;
    logic signed [TW-1:0]     r1_p;
    logic                     r2_valid;
    logic signed [NXW-1:0]    r2_nx;
    logic signed [TW-1:0]     r2_sum;
    logic signed [TW-1:0]     r2_hi;
    logic [RW-1:0]            r2_lo;
    logic                     r3_valid;
    logic signed [NXW-1:0]    r3_nx;
    logic signed [TW-1:0]     r3_sum;
    logic signed [TW-1:0]     r3_term;

    always_comb begin
        w_prod = (TW+NXW)'(i_bus.term) * (TW+NXW)'(i_bus.nx);
        n_p    = w_prod[TW+11:12];
        w_ph   = r1_p[TW-1:32];
        w_hi   = (TW+RW-31)'(w_ph) * $signed({1'b0, i_recip});
        w_lo   = r1_p[31:0] * i_recip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_bus.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_nx   <= i_bus.nx;
            r1_sum  <= i_bus.sum + i_bus.term;
            r1_p    <= n_p;
            r2_nx   <= r1_nx;
            r2_sum  <= r1_sum;
            r2_hi   <= w_hi[TW-1:0];
            r2_lo   <= w_lo[31+RW:32];
            r3_nx   <= r2_nx;
            r3_sum  <= r2_sum;
            r3_term <= r2_hi + $signed({{(TW-RW){1'b0}}, r2_lo});
        end
    end

    assign o_bus = '{valid: r3_valid, nx: r3_nx, term: r3_term, sum: r3_sum};
endmodule
`default_nettype wire

[hw/rtl/sigmoid_taylor_exp.sv]
// ----------------------------------------------------------------------------
// sigmoid_taylor_exp
// sigmoid of a Q4.12 activation through a taylor series of e^-x, Q0.16 out
// ----------------------------------------------------------------------------
// usage:
//   i_x carries one signed Q4.12 word x_in per valid/ready handshake,
//   o_y returns one unsigned Q0.16 word y_out per input word, in order.
//   one word is accepted every cycle while the result side keeps up.
//   pipeline: the taylor term units (TERMS-1 terms), the registers that
//   close the sum, the restoring division (one quotient bit a stage)
//   and 1 output register.
//   the term multipliers and the divider stages set the cycle time.
//   reset clears every valid bit; no word is in flight afterward.
//   when o_y stalls, one word parks in a skid register and the whole
//   pipeline then holds; i_x.ready drops only while the skid is full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sigmoid_taylor_exp_defines.svh"
module sigmoid_taylor_exp (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ste_x_if.sink     i_x,
    ste_y_if.source   o_y
);
    import ste_pkg::*;

    logic      w_en;
    logic      w_fire;
    t_term_bus w_bus [0:TERMS-1];

    logic                 r_f_valid;
    logic signed [TW-1:0] r_f_sum;

    logic            r_dv  [0:QW];
    logic [REMW-1:0] r_rem [0:QW];
    logic [REMW-1:0] r_d   [0:QW];
    logic [QW-1:0]   r_q   [0:QW];
    logic [SHW-1:0]  w_sh  [0:QW-1];
    logic            w_ge  [0:QW-1];

    logic [REMW-1:0] n_d;
    logic [15:0]     n_y;
    logic            r_out_valid;
    logic [15:0]     r_out_y;
    logic            r_skid_valid;
    logic [15:0]     r_skid_y;
    logic            n_out_valid;
    logic [15:0]     n_out_y;
    logic            n_skid_valid;
    logic [15:0]     n_skid_y;

    assign w_en   = !r_skid_valid;
    assign w_fire = r_out_valid && o_y.ready;
    assign i_x.ready = w_en;

    assign w_bus[0] = '{valid: i_x.valid,
                        nx:    NXW'(-$signed({i_x.x_in[15], i_x.x_in})),
                        term:  TW'(1) <<< FRAC,
                        sum:   '0};

    for (genvar k = 1; k < TERMS; k++) begin : g_term
        localparam logic [RW-1:0] RK = RW'((64'd1 << 32) / k);
        ste_term u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_recip (RK),
            .i_bus   (w_bus[k-1]),
            .o_bus   (w_bus[k])
        );
    end

    // close the sum, clamp at zero, form divisor and rounded dividend
    always_comb begin
        n_d = (REMW'(1) << FRAC) + (r_f_sum[TW-1] ? '0 : REMW'(r_f_sum));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_dv[0]   <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= w_bus[TERMS-1].valid;
            r_dv[0]   <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_sum  <= w_bus[TERMS-1].sum + w_bus[TERMS-1].term;
            r_d[0]   <= n_d;
            r_rem[0] <= (REMW'(1) << (FRAC + 16)) + (n_d >> 1);
            r_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        always_comb begin
            w_sh[j] = SHW'(r_d[j]) << (QW - 1 - j);
            w_ge[j] = SHW'(r_rem[j]) >= w_sh[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d[j+1]   <= r_d[j];
                r_rem[j+1] <= w_ge[j] ? REMW'(SHW'(r_rem[j]) - w_sh[j]) : r_rem[j];
                r_q[j+1]   <= {r_q[j][QW-2:0], w_ge[j]};
            end
        end
    end

    assign n_y = r_q[QW][QW-1] ? 16'hFFFF : r_q[QW][15:0];

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_y      = r_out_y;
        n_skid_valid = r_skid_valid;
        n_skid_y     = r_skid_y;
        if (w_fire) begin
            if (r_skid_valid) begin
                n_out_y      = r_skid_y;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = 1'b0;
            end
        end
        if (w_en && r_dv[QW]) begin
            if (!r_out_valid || w_fire) begin
                n_out_valid = 1'b1;
                n_out_y     = n_y;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_y     = n_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_y  <= n_out_y;
        r_skid_y <= n_skid_y;
    end

    assign o_y.valid = r_out_valid;
    assign o_y.y_out = r_out_y;

    `STE_ASSERT_IMPL(a_skid_has_out, r_skid_valid, r_out_valid)
    `STE_ASSERT_IMPL(a_quot_range, r_dv[QW], r_q[QW] <= 17'd65536)
    `STE_ASSERT_NEXT(a_out_held, r_out_valid && !o_y.ready, r_out_valid)
    `STE_ASSERT_NEXT(a_stall_holds, !w_en, $stable(r_dv[QW]))
endmodule
`default_nettype wire
